@@ sv/lph_pkg.sv @@
// package: types, constants and hash helpers for the linear probe hash map
package lph_pkg;

  localparam int SlotsDef     = 64;
  localparam int KeyBytesDef  = 8;
  localparam int ValueBitsDef = 32;

  localparam logic [63:0] FnvOffset = 64'hCBF29CE484222325;
  localparam logic [63:0] FnvPrime  = 64'd1099511628211;
  localparam logic [63:0] HashTop   = 64'h8000000000000000;

  typedef enum logic [1:0] {
    REQ_PUT    = 2'd0,
    REQ_GET    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EXISTS = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] key;
    logic [31:0] value;
  } req_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [6:0]  entry_count;
  } res_item_t;

  // hashed request handed from front to back
  typedef struct packed {
    req_t        op;
    logic [63:0] key;
    logic [63:0] hash;
    logic [63:0] value;
  } job_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_HASH,
    FE_PUSH
  } fe_state_t;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_READ,
    BE_CHECK,
    BE_INSERT,
    BE_WRITE,
    BE_DONE
  } be_state_t;

endpackage

@@ sv/linear_probe_hash_map_core.sv @@
// top level: hash map core with a hashing front end, job queue and probing back end
// usage:
//   raise start with req (req_type, key, value) while busy is low; the request is
//   taken at that edge and busy stays high until its result has been delivered.
//   the result appears on res for exactly one cycle with done high; the
//   receiver cannot stall it.
//   processing: the front end hashes the key with one shift-add multiply by the
//   fnv prime per key byte up to the first zero byte, then pushes the job into
//   the queue; the back end pops it, reads each probed slot from registered
//   memory and then compares it, writes the table and gives the result;
//   the unused request code skips the write.
//   one request is in flight at a time; the next can be taken the cycle after
//   done. slots must be a power of two.
//   reset clears the slot used and live flags and the entry count; no
//   clearing pass is needed and the block is ready the cycle after reset.
module linear_probe_hash_map_core #(
  parameter int SLOTS      = lph_pkg::SlotsDef,
  parameter int KEY_BYTES  = lph_pkg::KeyBytesDef,
  parameter int VALUE_BITS = lph_pkg::ValueBitsDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  lph_pkg::req_item_t req,
  output logic               busy,
  output logic               done,
  output lph_pkg::res_item_t res
);
  import lph_pkg::*;

  logic front_busy, back_busy, push, q_full, q_empty, pop;
  job_t job_in, job_out;

  lph_front #(.KEY_BYTES(KEY_BYTES), .VALUE_BITS(VALUE_BITS)) u_front (
    .clk, .rst, .start(start && !busy), .req, .front_busy,
    .push, .job(job_in), .q_full
  );

  lph_queue u_queue (
    .clk, .rst, .push, .din(job_in), .full(q_full),
    .pop, .empty(q_empty), .dout(job_out)
  );

  lph_back #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk, .rst, .q_empty, .job(job_out), .pop, .back_busy, .done, .res
  );

  assign busy = front_busy || back_busy || !q_empty;

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result without busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted request did not set busy");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    done |-> (res.entry_count <= 7'(SLOTS) || SLOTS > 64))
    else $error("entry count overflow");
  a_queue: assert property (@(posedge clk) disable iff (rst) !(push && q_full))
    else $error("push into full queue");

endmodule

@@ sv/lph_front.sv @@
// front end: accepts requests, cuts the key and computes the fnv-1a hash one byte a cycle
module lph_front #(
  parameter int KEY_BYTES  = lph_pkg::KeyBytesDef,
  parameter int VALUE_BITS = lph_pkg::ValueBitsDef
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  lph_pkg::req_item_t req,
  output logic              front_busy,
  output logic              push,
  output lph_pkg::job_t     job,
  input  logic              q_full
);
  import lph_pkg::*;

  localparam int BW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES + 1) : 1;

  fe_state_t state, state_next;
  logic [63:0] key_reg;
  logic [63:0] kept;
  logic [63:0] hash;
  logic [63:0] value_reg;
  req_t        op_reg;
  logic [BW-1:0] idx;
  logic [7:0]  cur_byte;
  logic        done_bytes;
  logic [63:0] mask;
  logic [63:0] mix;

  assign mask = (VALUE_BITS >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_BITS) - 64'd1);
  assign cur_byte   = key_reg[8*idx +: 8];
  assign done_bytes = (idx == BW'(KEY_BYTES)) || (cur_byte == 8'd0);
  assign mix        = hash ^ {56'd0, cur_byte};

  always_comb begin
    state_next = state;
    unique case (state)
      FE_IDLE: if (start) state_next = FE_HASH;
      FE_HASH: if (done_bytes) state_next = FE_PUSH;
      FE_PUSH: if (!q_full) state_next = FE_IDLE;
      default: state_next = FE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // prime is 2^40 + 0x1b3, so the product is a sum of shifted copies
  always_ff @(posedge clk) begin
    if (state == FE_IDLE && start) begin
      key_reg   <= req.key;
      value_reg <= {32'd0, req.value} & mask;
      op_reg    <= req_t'(req.req_type);
      kept      <= '0;
      hash      <= FnvOffset;
      idx       <= '0;
    end else if (state == FE_HASH && !done_bytes) begin
      hash <= (mix << 40) + (mix << 8) + (mix << 7) + (mix << 5) + (mix << 4)
            + (mix << 1) + mix;
      kept[8*idx +: 8] <= cur_byte;
      idx  <= idx + BW'(1);
    end
  end

  assign front_busy = (state != FE_IDLE);
  assign push       = (state == FE_PUSH) && !q_full;
  assign job.op     = op_reg;
  assign job.key    = kept;
  assign job.hash   = hash | HashTop;
  assign job.value  = value_reg;

endmodule

@@ sv/lph_queue.sv @@
// two-entry job queue between front and back ends
module lph_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lph_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output lph_pkg::job_t dout
);
  import lph_pkg::*;

  job_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

endmodule

@@ sv/lph_back.sv @@
// back end: reads then checks each probed slot in turn and applies the request
module lph_back #(
  parameter int SLOTS      = lph_pkg::SlotsDef,
  parameter int VALUE_BITS = lph_pkg::ValueBitsDef
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  lph_pkg::job_t     job,
  output logic              pop,
  output logic              back_busy,
  output logic              done,
  output lph_pkg::res_item_t res
);
  import lph_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  be_state_t state, state_next;
  logic [63:0]         hash_mem  [SLOTS];
  logic [63:0]         key_mem   [SLOTS];
  logic [VALUE_BITS-1:0] val_mem [SLOTS];
  logic [SLOTS-1:0]    live;
  logic [SLOTS-1:0]    used;

  job_t        cur;
  logic [AW-1:0] pos, ins_pos;
  logic [CW-1:0] n;
  logic          have_ins;
  logic [63:0]   rd_hash, rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic          rd_used, rd_live;
  logic [CW-1:0] live_count;
  logic [1:0]    st;
  logic [31:0]   rv;
  logic          hit, stop, cand, last;

  assign hit  = rd_used && rd_hash == cur.hash && rd_live && rd_key == cur.key;
  assign stop = !rd_used;
  assign cand = !rd_used || (rd_hash == cur.hash && !rd_live);
  assign last = (n == CW'(SLOTS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      BE_IDLE:  if (!q_empty) state_next = BE_READ;
      BE_READ:  state_next = BE_CHECK;
      BE_CHECK: begin
        if (cur.op == REQ_NONE) state_next = BE_DONE;
        else if (hit || stop || last) state_next = BE_WRITE;
        else state_next = BE_READ;
      end
      BE_INSERT: state_next = BE_DONE;
      BE_WRITE: state_next = BE_DONE;
      BE_DONE:  state_next = BE_IDLE;
      default:  state_next = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BE_IDLE;
      live  <= '0;
      used  <= '0;
      live_count <= '0;
    end else begin
      state <= state_next;
      if (state == BE_WRITE) begin
        if (cur.op == REQ_PUT && st == ST_OK) begin
          used[ins_pos] <= 1'b1;
          live[ins_pos] <= 1'b1;
          live_count <= live_count + CW'(1);
        end else if (cur.op == REQ_REMOVE && st == ST_OK) begin
          live[pos] <= 1'b0;
          live_count <= live_count - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_hash <= hash_mem[pos];
    rd_key  <= key_mem[pos];
    rd_val  <= val_mem[pos];
    rd_used <= used[pos];
    rd_live <= live[pos];
    if (state == BE_WRITE && cur.op == REQ_PUT && st == ST_OK) begin
      hash_mem[ins_pos] <= cur.hash;
      key_mem[ins_pos]  <= cur.key;
      val_mem[ins_pos]  <= cur.value[VALUE_BITS-1:0];
    end
  end

  // home slot is the low hash bits, slots a power of two
  always_ff @(posedge clk) begin
    unique case (state)
      BE_IDLE: if (!q_empty) begin
        cur <= job;
        pos <= job.hash[AW-1:0];
        n <= '0;
        have_ins <= 1'b0;
        st <= ST_OK;
        rv <= '0;
      end
      BE_CHECK: begin
        if (cur.op != REQ_NONE) begin
          if (cand && !have_ins) begin
            have_ins <= 1'b1;
            ins_pos <= pos;
          end
          if (hit) begin
            if (cur.op == REQ_PUT) st <= ST_EXISTS;
            else st <= ST_OK;
            if (cur.op == REQ_GET) rv <= 32'(rd_val);
          end else if (stop || last) begin
            if (cur.op == REQ_PUT) st <= (have_ins || cand) ? ST_OK : ST_FULL;
            else st <= ST_ABSENT;
            if (cur.op == REQ_PUT && !have_ins && cand) ins_pos <= pos;
          end else begin
            pos <= (pos == AW'(SLOTS - 1)) ? '0 : pos + AW'(1);
            n <= n + CW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign pop       = (state == BE_IDLE) && !q_empty;
  assign back_busy = (state != BE_IDLE);
  assign done      = (state == BE_DONE);
  assign res.status      = st;
  assign res.read_value  = rv;
  assign res.entry_count = 7'(live_count);

endmodule
